@@ src/cle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, codes and command name table for the command line editor
// and matcher.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int unsigned LINE_LIMIT_DEF  = 128;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned CFG_ADDR_W      = 3;
	localparam int unsigned NAME_COUNT      = 9;
	localparam int unsigned NAME_MAX        = 7;

	localparam logic REG_ENABLED = 1'b0;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [6:0] SEP_SPACE = 7'd32;
	localparam logic [6:0] SEP_TAB   = 7'd9;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OFF     = 2'd1;
	localparam logic [1:0] STATUS_LONG    = 2'd2;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

	localparam logic [1:0] ECHO_NONE    = 2'd0;
	localparam logic [1:0] ECHO_CHAR    = 2'd1;
	localparam logic [1:0] ECHO_ERASE   = 2'd2;
	localparam logic [1:0] ECHO_NEWLINE = 2'd3;

	localparam logic [3:0] CMD_NONE    = 4'd0;
	localparam logic [3:0] CMD_UNKNOWN = 4'd10;

	localparam logic [63:0] NAME_TEXT [NAME_COUNT] = '{
		64'("help"), 64'("echo"), 64'("clear"), 64'("uptime"), 64'("mem"),
		64'("pci"), 64'("keys"), 64'("threads"), 64'("version")
	};
	localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
		4'd4, 4'd4, 4'd5, 4'd6, 4'd3, 4'd3, 4'd4, 4'd7, 4'd7
	};

	typedef enum logic [2:0] {
		OP_NOP,
		OP_OFF,
		OP_BS,
		OP_PRINT,
		OP_EOL
	} cle_op_t;

	typedef struct packed {
		cle_op_t    op;
		logic [6:0] ch;
	} cle_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESULT
	} cle_state_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_WORD,
		PH_ARGS
	} cle_phase_t;

	function automatic logic is_sep(input logic [6:0] c);
		return (c == SEP_SPACE) || (c == SEP_TAB);
	endfunction

	function automatic logic [6:0] name_char(input int unsigned k, input logic [3:0] i);
		logic [63:0] text;
		logic [3:0]  pos;
		text = NAME_TEXT[k];
		pos  = NAME_LEN[k] - 4'd1 - i;
		return text[{pos[2:0], 3'b000} +: 7];
	endfunction

	function automatic logic [3:0] word_command(input logic [NAME_COUNT-1:0] hit,
			input logic [3:0] wlen);
		logic [3:0] cmd;
		cmd = CMD_UNKNOWN;
		for (int k = NAME_COUNT - 1; k >= 0; k--) begin
			if (hit[k] && (wlen == NAME_LEN[k])) begin
				cmd = 4'(k + 1);
			end
		end
		return cmd;
	endfunction

endpackage
`default_nettype wire

@@ src/command_line_editor_matcher_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// command_line_editor_matcher_core
// Line editor for a serial console that matches the first word of each line
// against nine command names and reports where the arguments lie.
// ----------------------------------------------------------------------------
// Each received character gives one result. Characters pass a classifying
// register and a short queue into the line engine; an editing character
// (printable, backspace, ignored or refused) is carried out by the engine
// in its idle state, so a run of them flows at one per cycle while each
// result is taken. A carriage return or line feed makes the engine walk the
// stored line through its single read port, alternating between a read
// state and an evaluate state as it steps through the characters;
// characters that arrive meanwhile wait in the queue. The register at
// offset 0 enables the block; until it is set every character is refused
// with the not initialized status.
// ----------------------------------------------------------------------------
module command_line_editor_matcher_core #(
	parameter int unsigned LINE_LIMIT  = cle_pkg::LINE_LIMIT_DEF,
	parameter int unsigned QUEUE_DEPTH = cle_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [cle_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  wire logic [7:0]                     char_code,
	input  wire logic                           char_valid,
	output logic                                char_ready,
	output logic [1:0]                          status,
	output logic [1:0]                          echo_kind,
	output logic [6:0]                          echo_char,
	output logic [3:0]                          command,
	output logic [7:0]                          arg_start,
	output logic [7:0]                          arg_length,
	output logic [31:0]                         line_count,
	output logic [31:0]                         command_count,
	output logic [31:0]                         unknown_count,
	output logic [31:0]                         rejected_count,
	output logic                                result_valid,
	input  wire logic                           result_ready
);

	logic              enabled_q;
	logic              reg_hit;
	cle_pkg::cle_req_t front_req;
	logic              front_valid;
	logic              front_ready;
	cle_pkg::cle_req_t queue_req;
	logic              queue_valid;
	logic              queue_ready;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[cle_pkg::CFG_ADDR_W-1] == cle_pkg::REG_ENABLED);
	assign prdata  = reg_hit ? {31'd0, enabled_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			enabled_q <= pwdata[0];
		end
	end

	cle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enabled    (enabled_q),
		.char_code  (char_code),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.req        (front_req),
		.req_valid  (front_valid),
		.req_ready  (front_ready)
	);

	cle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_req),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (queue_req),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	cle_back #(
		.LINE_LIMIT (LINE_LIMIT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (queue_req),
		.req_valid      (queue_valid),
		.req_ready      (queue_ready),
		.status         (status),
		.echo_kind      (echo_kind),
		.echo_char      (echo_char),
		.command        (command),
		.arg_start      (arg_start),
		.arg_length     (arg_length),
		.line_count     (line_count),
		.command_count  (command_count),
		.unknown_count  (unknown_count),
		.rejected_count (rejected_count),
		.result_valid   (result_valid),
		.result_ready   (result_ready)
	);

	a_echo_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (echo_kind == cle_pkg::ECHO_CHAR)
		|-> (status == cle_pkg::STATUS_OK) && (command == cle_pkg::CMD_NONE)
			&& (echo_char >= 7'd32))
		else $error("echoed character with bad status or code");

	a_unknown_no_args: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == cle_pkg::STATUS_UNKNOWN)
		|-> (command == cle_pkg::CMD_UNKNOWN) && (arg_start == 8'd0)
			&& (arg_length == 8'd0) && (echo_kind == cle_pkg::ECHO_NEWLINE))
		else $error("unknown command result malformed");

	a_known_at_eol: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (command != cle_pkg::CMD_NONE) && (command != cle_pkg::CMD_UNKNOWN)
		|-> (echo_kind == cle_pkg::ECHO_NEWLINE) && (status == cle_pkg::STATUS_OK))
		else $error("command reported outside a line end");

	a_line_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready
		|=> (line_count == $past(line_count)) || (line_count == $past(line_count) + 32'd1))
		else $error("line counter jumped");

endmodule
`default_nettype wire

@@ src/cle_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front
// Accepts received characters and classifies them into editing requests.
// ----------------------------------------------------------------------------
module cle_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              enabled,
	input  wire logic [7:0]        char_code,
	input  wire logic              char_valid,
	output logic                   char_ready,
	output cle_pkg::cle_req_t      req,
	output logic                   req_valid,
	input  wire logic              req_ready
);

	logic              valid_s1;
	cle_pkg::cle_req_t req_s1;
	cle_pkg::cle_req_t req_d;

	always_comb begin
		req_d.ch = char_code[6:0];
		if (!enabled) begin
			req_d.op = cle_pkg::OP_OFF;
		end else if ((char_code == cle_pkg::CH_LF) || (char_code == cle_pkg::CH_CR)) begin
			req_d.op = cle_pkg::OP_EOL;
		end else if (char_code == cle_pkg::CH_BS) begin
			req_d.op = cle_pkg::OP_BS;
		end else if ((char_code >= cle_pkg::CH_SPACE) && (char_code <= cle_pkg::CH_TILDE)) begin
			req_d.op = cle_pkg::OP_PRINT;
		end else begin
			req_d.op = cle_pkg::OP_NOP;
		end
	end

	assign char_ready = !valid_s1 || req_ready;
	assign req_valid  = valid_s1;
	assign req        = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			req_s1 <= req_d;
		end
	end

endmodule
`default_nettype wire

@@ src/cle_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_queue
// Short request queue between the classifier and the line engine.
// ----------------------------------------------------------------------------
module cle_queue #(
	parameter int unsigned DEPTH = cle_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cle_pkg::cle_req_t push_data,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output cle_pkg::cle_req_t      pop_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL  = CW'(DEPTH);

	cle_pkg::cle_req_t slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ src/cle_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back
// Line engine: holds the line store and counters, edits the line and walks
// it at a line end to match the command word.
// ----------------------------------------------------------------------------
module cle_back #(
	parameter int unsigned LINE_LIMIT = cle_pkg::LINE_LIMIT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cle_pkg::cle_req_t req,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic [1:0]             status,
	output logic [1:0]             echo_kind,
	output logic [6:0]             echo_char,
	output logic [3:0]             command,
	output logic [7:0]             arg_start,
	output logic [7:0]             arg_length,
	output logic [31:0]            line_count,
	output logic [31:0]            command_count,
	output logic [31:0]            unknown_count,
	output logic [31:0]            rejected_count,
	output logic                   result_valid,
	input  wire logic              result_ready
);

	localparam int unsigned AW = $clog2(LINE_LIMIT);
	localparam int unsigned LW = $clog2(LINE_LIMIT + 1);
	localparam logic [LW-1:0] LIMIT_L = LW'(LINE_LIMIT);
	localparam logic [3:0]    WI_MAX  = 4'(cle_pkg::NAME_MAX + 1);

	logic [6:0]                     store_q [LINE_LIMIT];
	logic [6:0]                     rdata_q;
	logic [LW-1:0]                  length_q;
	logic [LW-1:0]                  len_q;
	logic [LW-1:0]                  pos_q;
	logic [LW-1:0]                  res_arg_q;
	logic [3:0]                     wi_q;
	logic [cle_pkg::NAME_COUNT-1:0] match_q;
	logic [cle_pkg::NAME_COUNT-1:0] match_d;
	logic [3:0]                     scan_cmd_q;
	logic [3:0]                     res_cmd_q;
	cle_pkg::cle_state_t            state_q;
	cle_pkg::cle_state_t            state_d;
	cle_pkg::cle_phase_t            phase_q;
	logic                           out_valid_q;
	logic [1:0]                     status_q;
	logic [1:0]                     echo_kind_q;
	logic [6:0]                     echo_char_q;
	logic [3:0]                     command_q;
	logic [7:0]                     arg_start_q;
	logic [7:0]                     arg_length_q;
	logic [31:0]                    lines_q;
	logic [31:0]                    commands_q;
	logic [31:0]                    unknown_q;
	logic [31:0]                    refused_q;

	logic          out_load_ok;
	logic          pop;
	logic          load_simple;
	logic          load_eol;
	logic          at_end;
	logic          ch_sep;
	logic [3:0]    word_cmd;
	logic          word_end;
	logic          finish;
	logic          store_we;
	logic [LW-1:0] arg_len_w;
	logic [LW+7:0] arg_start_x;
	logic [LW+7:0] arg_len_x;

	assign out_load_ok = !out_valid_q || result_ready;
	assign at_end      = (pos_q == len_q);
	assign ch_sep      = cle_pkg::is_sep(rdata_q);
	assign word_cmd    = cle_pkg::word_command(match_q, wi_q);
	assign arg_len_w   = len_q - res_arg_q;
	assign arg_start_x = {8'd0, res_arg_q};
	assign arg_len_x   = {8'd0, arg_len_w};

	always_comb begin
		for (int k = 0; k < cle_pkg::NAME_COUNT; k++) begin
			match_d[k] = match_q[k] && (wi_q < cle_pkg::NAME_LEN[k])
				&& (rdata_q == cle_pkg::name_char(k, wi_q));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cle_pkg::ST_IDLE: begin
				if (req_valid && (req.op == cle_pkg::OP_EOL)) begin
					state_d = cle_pkg::ST_READ;
				end
			end
			cle_pkg::ST_READ: begin
				if (finish) begin
					state_d = cle_pkg::ST_RESULT;
				end else if (!at_end) begin
					state_d = cle_pkg::ST_EVAL;
				end
			end
			cle_pkg::ST_EVAL: begin
				state_d = finish ? cle_pkg::ST_RESULT : cle_pkg::ST_READ;
			end
			cle_pkg::ST_RESULT: begin
				if (out_load_ok) begin
					state_d = cle_pkg::ST_IDLE;
				end
			end
			default: state_d = cle_pkg::ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		pop         = 1'b0;
		load_simple = 1'b0;
		load_eol    = 1'b0;
		word_end    = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			cle_pkg::ST_IDLE: begin
				pop         = req_valid && ((req.op == cle_pkg::OP_EOL) || out_load_ok);
				load_simple = pop && (req.op != cle_pkg::OP_EOL);
			end
			cle_pkg::ST_READ: begin
				if (at_end) begin
					word_end = (phase_q == cle_pkg::PH_WORD);
					finish   = (phase_q != cle_pkg::PH_WORD) || (word_cmd == cle_pkg::CMD_UNKNOWN);
				end
			end
			cle_pkg::ST_EVAL: begin
				unique case (phase_q)
					cle_pkg::PH_WORD: begin
						word_end = ch_sep;
						finish   = ch_sep && (word_cmd == cle_pkg::CMD_UNKNOWN);
					end
					cle_pkg::PH_ARGS: finish = !ch_sep;
					default: finish = 1'b0;
				endcase
			end
			cle_pkg::ST_RESULT: load_eol = out_load_ok;
			default: pop = 1'b0;
		endcase
	end

	assign req_ready = pop;
	assign store_we  = load_simple && (req.op == cle_pkg::OP_PRINT) && (length_q != LIMIT_L);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cle_pkg::ST_IDLE;
			phase_q     <= cle_pkg::PH_LEAD;
			out_valid_q <= 1'b0;
			length_q    <= '0;
			lines_q     <= '0;
			commands_q  <= '0;
			unknown_q   <= '0;
			refused_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load_simple || load_eol) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && (req.op == cle_pkg::OP_EOL)) begin
				phase_q <= cle_pkg::PH_LEAD;
			end else if (word_end) begin
				phase_q <= cle_pkg::PH_ARGS;
			end else if ((state_q == cle_pkg::ST_EVAL) && (phase_q == cle_pkg::PH_LEAD) && !ch_sep) begin
				phase_q <= cle_pkg::PH_WORD;
			end
			if (load_simple) begin
				if ((req.op == cle_pkg::OP_BS) && (length_q != '0)) begin
					length_q <= length_q - LW'(1);
				end else if (req.op == cle_pkg::OP_PRINT) begin
					if (length_q == LIMIT_L) begin
						refused_q <= refused_q + 32'd1;
					end else begin
						length_q <= length_q + LW'(1);
					end
				end
			end
			if (load_eol) begin
				length_q <= '0;
				lines_q  <= lines_q + 32'd1;
				if (res_cmd_q == cle_pkg::CMD_UNKNOWN) begin
					unknown_q <= unknown_q + 32'd1;
				end else if (res_cmd_q != cle_pkg::CMD_NONE) begin
					commands_q <= commands_q + 32'd1;
				end
			end
		end
	end

	// line store and scan datapath
	always_ff @(posedge clk) begin
		rdata_q <= store_q[pos_q[AW-1:0]];
		if (store_we) begin
			store_q[length_q[AW-1:0]] <= req.ch;
		end
		if (pop && (req.op == cle_pkg::OP_EOL)) begin
			len_q   <= length_q;
			pos_q   <= '0;
			wi_q    <= '0;
			match_q <= '1;
		end else if (state_q == cle_pkg::ST_EVAL) begin
			unique case (phase_q)
				cle_pkg::PH_LEAD: begin
					if (ch_sep) begin
						pos_q <= pos_q + LW'(1);
					end
				end
				cle_pkg::PH_WORD: begin
					if (!ch_sep) begin
						match_q <= match_d;
						wi_q    <= (wi_q == WI_MAX) ? WI_MAX : wi_q + 4'd1;
						pos_q   <= pos_q + LW'(1);
					end
				end
				cle_pkg::PH_ARGS: begin
					if (ch_sep) begin
						pos_q <= pos_q + LW'(1);
					end
				end
				default: pos_q <= pos_q;
			endcase
		end
		if (word_end) begin
			scan_cmd_q <= word_cmd;
		end
		if (finish) begin
			res_arg_q <= pos_q;
			unique case (phase_q)
				cle_pkg::PH_LEAD: res_cmd_q <= cle_pkg::CMD_NONE;
				cle_pkg::PH_WORD: res_cmd_q <= cle_pkg::CMD_UNKNOWN;
				default:          res_cmd_q <= scan_cmd_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_simple) begin
			status_q     <= cle_pkg::STATUS_OK;
			echo_kind_q  <= cle_pkg::ECHO_NONE;
			echo_char_q  <= '0;
			command_q    <= cle_pkg::CMD_NONE;
			arg_start_q  <= '0;
			arg_length_q <= '0;
			unique case (req.op)
				cle_pkg::OP_OFF: status_q <= cle_pkg::STATUS_OFF;
				cle_pkg::OP_BS: begin
					if (length_q != '0) begin
						echo_kind_q <= cle_pkg::ECHO_ERASE;
					end
				end
				cle_pkg::OP_PRINT: begin
					if (length_q == LIMIT_L) begin
						status_q <= cle_pkg::STATUS_LONG;
					end else begin
						echo_kind_q <= cle_pkg::ECHO_CHAR;
						echo_char_q <= req.ch;
					end
				end
				default: status_q <= cle_pkg::STATUS_OK;
			endcase
		end else if (load_eol) begin
			echo_kind_q <= cle_pkg::ECHO_NEWLINE;
			echo_char_q <= '0;
			command_q   <= res_cmd_q;
			if (res_cmd_q == cle_pkg::CMD_UNKNOWN) begin
				status_q     <= cle_pkg::STATUS_UNKNOWN;
				arg_start_q  <= '0;
				arg_length_q <= '0;
			end else if (res_cmd_q == cle_pkg::CMD_NONE) begin
				status_q     <= cle_pkg::STATUS_OK;
				arg_start_q  <= '0;
				arg_length_q <= '0;
			end else begin
				status_q     <= cle_pkg::STATUS_OK;
				arg_start_q  <= arg_start_x[7:0];
				arg_length_q <= arg_len_x[7:0];
			end
		end
	end

	assign result_valid   = out_valid_q;
	assign status         = status_q;
	assign echo_kind      = echo_kind_q;
	assign echo_char      = echo_char_q;
	assign command        = command_q;
	assign arg_start      = arg_start_q;
	assign arg_length     = arg_length_q;
	assign line_count     = lines_q;
	assign command_count  = commands_q;
	assign unknown_count  = unknown_q;
	assign rejected_count = refused_q;

endmodule
`default_nettype wire
